### rtl/esd_pkg.sv
`timescale 1ns / 1ps

package esd_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int QDEPTH      = 2;
  localparam int QPTR_BITS   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int FILL_BITS   = $clog2(QDEPTH + 1);
  localparam int MAX_RESULTS = 10;

  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [7:0]  CH_BSLASH  = 8'h5C;
  localparam logic [7:0]  CH_X       = 8'h78;
  localparam logic [7:0]  CH_LU      = 8'h75;
  localparam logic [7:0]  CH_UU      = 8'h55;
  localparam logic [7:0]  CH_ESC     = 8'h1B;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [31:0] CODE_MAX   = 32'h0010FFFF;
  localparam logic [31:0] SURR_MASK  = 32'h0000F800;
  localparam logic [31:0] SURR_BASE  = 32'h0000D800;

  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_HEX,
    MODE_OCT,
    MODE_UNI
  } mode_t;

  typedef enum logic [2:0] {
    GRP_NONE,
    GRP_BYTE,
    GRP_LIT_X,
    GRP_UNI_LIT,
    GRP_UTF8
  } group_t;

  // One decoded input byte: an optional group of bytes, then an optional copy of the raw byte.
  typedef struct packed {
    group_t          group;
    logic [3:0]      glen;
    logic [20:0]     value;
    logic            wide;
    logic [6:0][7:0] digits;
    logic            emit_c;
    logic [7:0]      c;
    logic            last;
  } cmd_t;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0_0000;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [3:0] utf8_len(input logic [20:0] v);
    logic [3:0] r;
    if (v < 21'h80) begin
      r = 4'd1;
    end else if (v < 21'h800) begin
      r = 4'd2;
    end else if (v < 21'h10000) begin
      r = 4'd3;
    end else begin
      r = 4'd4;
    end
    return r;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] v, input logic [3:0] len,
                                           input logic [3:0] k);
    logic [7:0] r;
    r = 8'h00;
    case (len)
      4'd1: r = {1'b0, v[6:0]};
      4'd2: begin
        case (k)
          4'd0:    r = UTF8_LEAD2 | {3'b000, v[10:6]};
          default: r = UTF8_CONT | {2'b00, v[5:0]};
        endcase
      end
      4'd3: begin
        case (k)
          4'd0:    r = UTF8_LEAD3 | {4'b0000, v[15:12]};
          4'd1:    r = UTF8_CONT | {2'b00, v[11:6]};
          default: r = UTF8_CONT | {2'b00, v[5:0]};
        endcase
      end
      default: begin
        case (k)
          4'd0:    r = UTF8_LEAD4 | {5'b00000, v[20:18]};
          4'd1:    r = UTF8_CONT | {2'b00, v[17:12]};
          4'd2:    r = UTF8_CONT | {2'b00, v[11:6]};
          default: r = UTF8_CONT | {2'b00, v[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [15:0] sat16(input count_t x);
    logic [31:0] w;
    w = 32'(x);
    return (w > 32'h0000FFFF) ? 16'hFFFF : w[15:0];
  endfunction

endpackage

### rtl/esd_front.sv
`timescale 1ns / 1ps

module esd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_stall,
  input  logic [7:0]    in_byte,
  input  logic          is_last,
  output logic          push,
  output esd_pkg::cmd_t cmd
);
  import esd_pkg::*;

  mode_t           mode, mode_step, mode_next;
  logic [3:0]      digit_count, digit_count_next, cnt_inc, need;
  logic [31:0]     code_value, code_value_next, uni_code;
  logic            wide_form, wide_form_next, wide_lit;
  logic [1:0]      octal_limit, octal_limit_next;
  logic [6:0][7:0] saved, saved_next;
  logic [4:0]      hex;
  logic            hex_ok, oct_ok, uni_bad, consumed, accept;
  group_t          grp;
  logic [20:0]     gval;
  logic [2:0]      nlit;
  logic            emit_c;
  logic [3:0]      glen;

  assign accept   = in_valid && !in_stall;
  assign hex      = hex_val(in_byte);
  assign hex_ok   = hex[4];
  assign oct_ok   = (in_byte[7:3] == 5'b00110);
  assign cnt_inc  = 4'(digit_count + 4'd1);
  assign need     = wide_form ? 4'd8 : 4'd4;
  assign uni_code = {code_value[27:0], hex[3:0]};
  assign uni_bad  = (uni_code > CODE_MAX) || ((uni_code & SURR_MASK) == SURR_BASE);
  assign consumed = (mode == MODE_ESC) || ((mode == MODE_HEX) && hex_ok) ||
                    ((mode == MODE_OCT) && oct_ok) || ((mode == MODE_UNI) && hex_ok);

  always_comb begin
    mode_step = mode;
    case (mode)
      MODE_HEX: begin
        if (!hex_ok || cnt_inc >= 4'd2) begin
          mode_step = MODE_PLAIN;
        end
      end
      MODE_OCT: begin
        if (!oct_ok || cnt_inc >= {2'b00, octal_limit}) begin
          mode_step = MODE_PLAIN;
        end
      end
      MODE_UNI: begin
        if (!hex_ok || cnt_inc >= need) begin
          mode_step = MODE_PLAIN;
        end
      end
      MODE_ESC: begin
        if (in_byte == CH_X) begin
          mode_step = MODE_HEX;
        end else if (in_byte == CH_LU || in_byte == CH_UU) begin
          mode_step = MODE_UNI;
        end else if (oct_ok) begin
          mode_step = MODE_OCT;
        end else begin
          mode_step = MODE_PLAIN;
        end
      end
      default: mode_step = MODE_PLAIN;
    endcase
    if (!consumed && in_byte == CH_BSLASH) begin
      mode_step = MODE_ESC;
    end
    mode_next = is_last ? MODE_PLAIN : mode_step;
  end

  always_comb begin
    digit_count_next = digit_count;
    code_value_next  = code_value;
    wide_form_next   = wide_form;
    octal_limit_next = octal_limit;
    saved_next       = saved;
    grp              = GRP_NONE;
    gval             = '0;
    nlit             = '0;
    emit_c           = 1'b0;
    case (mode)
      MODE_HEX: begin
        if (hex_ok) begin
          code_value_next  = {24'h000000, code_value[3:0], hex[3:0]};
          digit_count_next = cnt_inc;
          if (cnt_inc >= 4'd2) begin
            grp  = GRP_BYTE;
            gval = {13'h0000, code_value_next[7:0]};
          end
        end else if (digit_count == 4'd0) begin
          grp = GRP_LIT_X;
        end else begin
          grp  = GRP_BYTE;
          gval = {13'h0000, code_value[7:0]};
        end
      end
      MODE_OCT: begin
        if (oct_ok) begin
          code_value_next  = {24'h000000, code_value[4:0], in_byte[2:0]};
          digit_count_next = cnt_inc;
          if (cnt_inc >= {2'b00, octal_limit}) begin
            grp  = GRP_BYTE;
            gval = {13'h0000, code_value_next[7:0]};
          end
        end else begin
          grp  = GRP_BYTE;
          gval = {13'h0000, code_value[7:0]};
        end
      end
      MODE_UNI: begin
        if (hex_ok) begin
          if (digit_count < 4'd7) begin
            saved_next[digit_count[2:0]] = in_byte;
          end
          code_value_next  = uni_code;
          digit_count_next = cnt_inc;
          if (cnt_inc >= need) begin
            if (uni_bad) begin
              grp    = GRP_UNI_LIT;
              nlit   = 3'(need - 4'd1);
              emit_c = 1'b1;
            end else begin
              grp  = GRP_UTF8;
              gval = uni_code[20:0];
            end
          end
        end else begin
          grp  = GRP_UNI_LIT;
          nlit = digit_count[2:0];
        end
      end
      MODE_ESC: begin
        digit_count_next = '0;
        code_value_next  = '0;
        grp              = GRP_BYTE;
        case (in_byte)
          "n":     gval = 21'h0A;
          "r":     gval = 21'h0D;
          "t":     gval = 21'h09;
          "b":     gval = 21'h08;
          "f":     gval = 21'h0C;
          "a":     gval = 21'h07;
          "v":     gval = 21'h0B;
          "e":     gval = {13'h0000, CH_ESC};
          CH_X:    grp = GRP_NONE;
          CH_LU: begin
            grp            = GRP_NONE;
            wide_form_next = 1'b0;
          end
          CH_UU: begin
            grp            = GRP_NONE;
            wide_form_next = 1'b1;
          end
          default: begin
            if (oct_ok) begin
              grp              = GRP_NONE;
              code_value_next  = {29'h0, in_byte[2:0]};
              octal_limit_next = in_byte[2] ? 2'd1 : 2'd2;
            end else begin
              gval = {13'h0000, in_byte};
            end
          end
        endcase
      end
      default: ;
    endcase
    if (!consumed && in_byte != CH_BSLASH) begin
      emit_c = 1'b1;
    end
    wide_lit = wide_form_next;
    if (is_last) begin
      case (mode_step)
        MODE_HEX: begin
          if (digit_count_next == 4'd0) begin
            grp = GRP_LIT_X;
          end else begin
            grp  = GRP_BYTE;
            gval = {13'h0000, code_value_next[7:0]};
          end
        end
        MODE_OCT: begin
          grp  = GRP_BYTE;
          gval = {13'h0000, code_value_next[7:0]};
        end
        MODE_UNI: begin
          grp  = GRP_UNI_LIT;
          nlit = digit_count_next[2:0];
        end
        default: ;
      endcase
      digit_count_next = '0;
      code_value_next  = '0;
      wide_form_next   = 1'b0;
      octal_limit_next = '0;
    end
  end

  always_comb begin
    case (grp)
      GRP_BYTE:    glen = 4'd1;
      GRP_LIT_X:   glen = 4'd2;
      GRP_UNI_LIT: glen = 4'(4'd2 + {1'b0, nlit});
      GRP_UTF8:    glen = utf8_len(gval);
      default:     glen = 4'd0;
    endcase
  end

  assign cmd.group  = grp;
  assign cmd.glen   = glen;
  assign cmd.value  = gval;
  assign cmd.wide   = wide_lit;
  assign cmd.digits = saved_next;
  assign cmd.emit_c = emit_c;
  assign cmd.c      = in_byte;
  assign cmd.last   = is_last;
  assign push       = accept && ((grp != GRP_NONE) || emit_c || is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_PLAIN;
      digit_count <= '0;
      code_value  <= '0;
      wide_form   <= 1'b0;
      octal_limit <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      digit_count <= digit_count_next;
      code_value  <= code_value_next;
      wide_form   <= wide_form_next;
      octal_limit <= octal_limit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      saved <= saved_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && is_last) |=> (mode == MODE_PLAIN && digit_count == 4'd0 && !wide_form))
    else $error("parser state not cleared after the last beat of a string");
`endif

endmodule

### rtl/esd_queue.sv
`timescale 1ns / 1ps

module esd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  esd_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          pop,
  output esd_pkg::cmd_t rd_cmd,
  output logic          not_empty
);
  import esd_pkg::*;

  cmd_t                 entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [FILL_BITS-1:0] fill;

  assign full      = (fill == FILL_BITS'(QDEPTH));
  assign not_empty = (fill != '0);
  assign rd_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : QPTR_BITS'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : QPTR_BITS'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        fill <= FILL_BITS'(fill + 1'b1);
      end else if (pop && !push) begin
        fill <= FILL_BITS'(fill - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("command queue popped while empty");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill <= FILL_BITS'(QDEPTH)) && !(push && full && !pop))
    else $error("command queue overflow");
`endif

endmodule

### rtl/esd_back.sv
`timescale 1ns / 1ps

module esd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  esd_pkg::cmd_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          byte_valid,
  output logic          run_last,
  output logic          string_end,
  output logic [15:0]   out_length
);
  import esd_pkg::*;

  logic [3:0] idx, total;
  count_t     cnt, cnt_inc;
  logic       load, marker, final_beat;
  logic [2:0] dsel;
  logic [7:0] gbyte, cur_byte;

  assign total      = 4'(head.glen + {3'b000, head.emit_c});
  assign marker     = (total == 4'd0);
  assign final_beat = marker || (idx == 4'(total - 4'd1));
  assign load       = head_valid && (!out_valid || !out_stall);
  assign pop        = load && final_beat;
  assign cnt_inc    = (cnt == COUNT_MAX) ? cnt : count_t'(cnt + count_t'(1));
  assign dsel       = 3'(idx - 4'd2);

  always_comb begin
    gbyte = 8'h00;
    case (head.group)
      GRP_BYTE:  gbyte = head.value[7:0];
      GRP_LIT_X: gbyte = (idx == 4'd0) ? CH_BSLASH : CH_X;
      GRP_UNI_LIT: begin
        if (idx == 4'd0) begin
          gbyte = CH_BSLASH;
        end else if (idx == 4'd1) begin
          gbyte = head.wide ? CH_UU : CH_LU;
        end else if (dsel != 3'd7) begin
          gbyte = head.digits[dsel];
        end
      end
      GRP_UTF8: gbyte = utf8_byte(head.value, head.glen, idx);
      default:  gbyte = 8'h00;
    endcase
    cur_byte = (idx < head.glen) ? gbyte : head.c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
      cnt       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= final_beat ? 4'd0 : 4'(idx + 4'd1);
      if (final_beat && head.last) begin
        cnt <= '0;
      end else if (!marker) begin
        cnt <= cnt_inc;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= marker ? 8'h00 : cur_byte;
      byte_valid <= !marker;
      run_last   <= final_beat;
      string_end <= final_beat && head.last;
      out_length <= sat16(marker ? cnt : cnt_inc);
    end
  end

`ifndef NO_ASSERTIONS
  a_marker_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> (run_last && string_end))
    else $error("empty end marker not flagged as end of string");
  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    (load && final_beat && head.last) |=> (cnt == '0))
    else $error("length count not cleared after end of string");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (idx < 4'(MAX_RESULTS) && (marker || idx < total)))
    else $error("result index ran past the command");
`endif

endmodule

### rtl/escape_sequence_decoder_top.sv
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// input     in_valid / in_stall  in_byte[7:0], is_last
// output    out_valid/ out_stall out_byte[7:0], byte_valid, run_last, string_end,
//                                out_length[15:0]
// The front parses one input beat per cycle unless stalled and queues at most one command per beat.
// Unless stalled, the back sends one result beat per cycle from the head command, 1 to 10 beats each.
// in_stall is high while the two-entry command queue is full.
// Reset is synchronous; there is no clearing pass.
// A stall on the output holds the result register and lets the queue fill.
module escape_sequence_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        run_last,
  output logic        string_end,
  output logic [15:0] out_length
);
  import esd_pkg::*;

  cmd_t wr_cmd, rd_cmd;
  logic push, pop, q_full, q_not_empty;

  assign in_stall = q_full;

  esd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (q_full),
    .in_byte  (in_byte),
    .is_last  (is_last),
    .push     (push),
    .cmd      (wr_cmd)
  );

  esd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_cmd    (wr_cmd),
    .full      (q_full),
    .pop       (pop),
    .rd_cmd    (rd_cmd),
    .not_empty (q_not_empty)
  );

  esd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_not_empty),
    .head       (rd_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .string_end (string_end),
    .out_length (out_length)
  );

endmodule
